// ----- rtl/core/assert_macros.svh -----
// assertion macros for the top level of the prime tester
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property checked on every rising edge outside reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion lbl failed");

// expression that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
    `ASSERT_CLK(lbl, clk, rstn, !(expr))

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)

`endif

`endif

// ----- rtl/core/mrpt_pkg.sv -----
// shared constants and types of the miller-rabin prime tester
package mrpt_pkg;

    localparam int NUM_W     = 32;
    localparam int RND_W     = 4;
    localparam int SHIFT_W   = $clog2(NUM_W);
    localparam int MUL_STEPS = 2 * NUM_W;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = NUM_W;
    localparam int OUT_W     = ((NUM_W + 1 + 7) / 8) * 8;

    localparam logic [NUM_W-1:0] LFSR_TAPS  = 32'hD000_0001;
    localparam logic [NUM_W-1:0] LFSR_RESET = 32'd1;
    localparam logic [RND_W-1:0] ROUNDS_RESET = 4'd5;
    localparam logic [RND_W-1:0] MAX_ROUNDS   = 4'd8;
    localparam logic [NUM_W-1:0] TWO  = 32'd2;
    localparam logic [NUM_W-1:0] FOUR = 32'd4;
    localparam logic [NUM_W-1:0] FIVE = 32'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROUND_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANDOM_SEED = 1'b1;

    // operation currently running in the shared modular multiplier
    typedef enum logic [1:0] {
        OP_WITNESS = 2'd0,
        OP_MUL     = 2'd1,
        OP_SQR     = 2'd2,
        OP_LOOP    = 2'd3
    } mm_op_t;

    // request to the shared modular multiplier
    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] a;
        logic [NUM_W-1:0] b;
        logic [NUM_W-1:0] m;
    } mm_req_t;

    // response of the shared modular multiplier
    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] result;
    } mm_rsp_t;

    // finished verdict from the sequencer
    typedef struct packed {
        logic             finish;
        logic             prime;
        logic [NUM_W-1:0] value;
    } ctrl_res_t;

endpackage

// ----- rtl/core/mrpt_lfsr.sv -----
// seedable 32-bit galois lfsr that draws witnesses
module mrpt_lfsr (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      seed_we,
    input  logic [mrpt_pkg::NUM_W-1:0] seed,
    input  logic                      step,
    output logic [mrpt_pkg::NUM_W-1:0] state
);
    import mrpt_pkg::*;

    logic [NUM_W-1:0] state_reg;
    logic [NUM_W-1:0] state_next;

    // seed load wins, zero seed maps to one
    always_comb
    begin
        state_next = state_reg;
        if (seed_we)
        begin
            state_next = (seed == '0) ? LFSR_RESET : seed;
        end
        else if (step)
        begin
            state_next = {1'b0, state_reg[NUM_W-1:1]};
            if (state_reg[0])
            begin
                state_next = state_next ^ LFSR_TAPS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LFSR_RESET;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

// ----- rtl/core/mrpt_mulmod.sv -----
// shared modular multiplier: one product, then bit-serial 64-by-32 reduction
module mrpt_mulmod (
    input  logic              clk,
    input  logic              rst_n,
    input  mrpt_pkg::mm_req_t req,
    output mrpt_pkg::mm_rsp_t rsp
);
    import mrpt_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [2*NUM_W-1:0]     prod_reg, prod_next;
    logic [NUM_W-1:0]       rem_reg, rem_next;
    logic [NUM_W-1:0]       mod_reg, mod_next;
    logic [NUM_W:0]         trial;
    logic [NUM_W:0]         trial_sub;

    // one restoring step: bring in the next product bit, subtract if it fits
    assign trial     = {rem_reg, prod_reg[2*NUM_W-1]};
    assign trial_sub = trial - {1'b0, mod_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        rem_next  = rem_reg;
        mod_next  = mod_reg;
        if (req.start && !busy_reg)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(MUL_STEPS - 1);
            prod_next = {{NUM_W{1'b0}}, req.a} * {{NUM_W{1'b0}}, req.b};
            rem_next  = '0;
            mod_next  = req.m;
        end
        else if (busy_reg)
        begin
            prod_next = {prod_reg[2*NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, mod_reg})
            begin
                rem_next = trial_sub[NUM_W-1:0];
            end
            else
            begin
                rem_next = trial[NUM_W-1:0];
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        mod_reg  <= mod_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = rem_reg;

endmodule

// ----- rtl/core/mrpt_ctrl.sv -----
// sequencer: decomposition, witness rounds and square-and-multiply
module mrpt_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [mrpt_pkg::NUM_W-1:0]  in_data,
    output logic                        in_ready,
    input  logic [mrpt_pkg::RND_W-1:0]  rounds,
    input  logic [mrpt_pkg::NUM_W-1:0]  lfsr_state,
    output logic                        lfsr_step,
    output mrpt_pkg::mm_req_t           mm_req,
    input  mrpt_pkg::mm_rsp_t           mm_rsp,
    input  logic                        out_free,
    output mrpt_pkg::ctrl_res_t         res
);
    import mrpt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_DECOMP = 8'b0000_0010,
        S_RSTEP  = 8'b0000_0100,
        S_RMOD   = 8'b0000_1000,
        S_WAIT   = 8'b0001_0000,
        S_POW    = 8'b0010_0000,
        S_CHECK  = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

    state_t             state_reg, state_next;
    mm_op_t             op_reg, op_next;
    logic [RND_W-1:0]   left_reg, left_next;
    logic [SHIFT_W-1:0] s_reg, s_next;
    logic [SHIFT_W-1:0] j_reg, j_next;
    logic               prime_reg, prime_next;
    logic [NUM_W-1:0]   n_reg, n_next;
    logic [NUM_W-1:0]   d_reg, d_next;
    logic [NUM_W-1:0]   e_reg, e_next;
    logic [NUM_W-1:0]   b_reg, b_next;
    logic [NUM_W-1:0]   acc_reg, acc_next;
    logic [NUM_W-1:0]   n_minus1;
    logic               round_pass;
    logic               round_fail;

    assign n_minus1 = n_reg - 1'b1;

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        left_next  = left_reg;
        s_next     = s_reg;
        j_next     = j_reg;
        prime_next = prime_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        e_next     = e_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;
        lfsr_step  = 1'b0;
        round_pass = 1'b0;
        round_fail = 1'b0;
        mm_req.start = 1'b0;
        mm_req.a     = acc_reg;
        mm_req.b     = b_reg;
        mm_req.m     = n_reg;

        case (state_reg)
            // take a candidate, settle the small ones at once
            S_IDLE:
            begin
                if (in_valid)
                begin
                    n_next = in_data;
                    if (in_data < TWO || in_data == FOUR)
                    begin
                        prime_next = 1'b0;
                        state_next = S_FINISH;
                    end
                    else if (in_data < FIVE)
                    begin
                        prime_next = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        d_next     = in_data - 1'b1;
                        s_next     = '0;
                        left_next  = rounds;
                        state_next = S_DECOMP;
                    end
                end
            end
            // strip factors of two from n-1, one a cycle
            S_DECOMP:
            begin
                if (!d_reg[0])
                begin
                    d_next = {1'b0, d_reg[NUM_W-1:1]};
                    s_next = s_reg + 1'b1;
                end
                else
                begin
                    state_next = S_RSTEP;
                end
            end
            S_RSTEP:
            begin
                lfsr_step  = 1'b1;
                state_next = S_RMOD;
            end
            // witness offset: r mod (n-4)
            S_RMOD:
            begin
                mm_req.start = 1'b1;
                mm_req.a     = lfsr_state;
                mm_req.b     = NUM_W'(1);
                mm_req.m     = n_reg - FOUR;
                op_next      = OP_WITNESS;
                e_next       = d_reg;
                acc_next     = NUM_W'(1);
                state_next   = S_WAIT;
            end
            // square-and-multiply over the exponent bits
            S_POW:
            begin
                if (e_reg == '0)
                begin
                    state_next = S_CHECK;
                end
                else if (e_reg[0])
                begin
                    mm_req.start = 1'b1;
                    op_next      = OP_MUL;
                    state_next   = S_WAIT;
                end
                else
                begin
                    mm_req.start = 1'b1;
                    mm_req.a     = b_reg;
                    op_next      = OP_SQR;
                    state_next   = S_WAIT;
                end
            end
            // first look at x = a^d mod n
            S_CHECK:
            begin
                if (acc_reg == NUM_W'(1) || acc_reg == n_minus1)
                begin
                    round_pass = 1'b1;
                end
                else if (s_reg <= SHIFT_W'(1))
                begin
                    round_fail = 1'b1;
                end
                else
                begin
                    j_next       = s_reg - 1'b1;
                    mm_req.start = 1'b1;
                    mm_req.b     = acc_reg;
                    op_next      = OP_LOOP;
                    state_next   = S_WAIT;
                end
            end
            // wait for the multiplier, then act on its result
            S_WAIT:
            begin
                if (mm_rsp.done)
                begin
                    case (op_reg)
                        OP_WITNESS:
                        begin
                            b_next     = mm_rsp.result + TWO;
                            state_next = S_POW;
                        end
                        OP_MUL:
                        begin
                            acc_next   = mm_rsp.result;
                            e_next     = {e_reg[NUM_W-1:1], 1'b0};
                            state_next = S_POW;
                        end
                        OP_SQR:
                        begin
                            b_next     = mm_rsp.result;
                            e_next     = {1'b0, e_reg[NUM_W-1:1]};
                            state_next = S_POW;
                        end
                        OP_LOOP:
                        begin
                            acc_next = mm_rsp.result;
                            if (mm_rsp.result == NUM_W'(1))
                            begin
                                round_fail = 1'b1;
                            end
                            else if (mm_rsp.result == n_minus1)
                            begin
                                round_pass = 1'b1;
                            end
                            else if (j_reg == SHIFT_W'(1))
                            begin
                                round_fail = 1'b1;
                            end
                            else
                            begin
                                j_next       = j_reg - 1'b1;
                                mm_req.start = 1'b1;
                                mm_req.a     = mm_rsp.result;
                                mm_req.b     = mm_rsp.result;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // hand the verdict over once the output slot is free
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // round outcome: early exit on failure
        if (round_fail)
        begin
            prime_next = 1'b0;
            state_next = S_FINISH;
        end
        else if (round_pass)
        begin
            if (left_reg <= RND_W'(1))
            begin
                prime_next = 1'b1;
                state_next = S_FINISH;
            end
            else
            begin
                left_next  = left_reg - 1'b1;
                state_next = S_RSTEP;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_WITNESS;
            left_reg  <= '0;
            s_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            left_reg  <= left_next;
            s_reg     <= s_next;
            j_reg     <= j_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prime_reg <= prime_next;
        n_reg     <= n_next;
        d_reg     <= d_next;
        e_reg     <= e_next;
        b_reg     <= b_next;
        acc_reg   <= acc_next;
    end

    assign in_ready   = (state_reg == S_IDLE);
    assign res.finish = (state_reg == S_FINISH);
    assign res.prime  = prime_reg;
    assign res.value  = n_reg;

endmodule

// ----- rtl/core/miller_rabin_prime_test.sv -----
// top level of the miller-rabin prime tester
// Tests one unsigned 32-bit candidate at a time and returns one item with the
// verdict and the candidate echoed. s_tready is high only while the block is
// idle. Candidates 0..4 are settled in the cycle after they are taken. Any
// other candidate first has n-1 split into d * 2^s, then each round takes the
// witness product and at most M = bitlength(d) + popcount(d) + (s - 1) further
// modular products, all through the single shared multiplier: an issue step
// that also forms the 64-bit product, a one-bit restoring reduction step per
// product bit and a registered hand-back of the result. A failing round ends
// the test at once.
// The result sits in an output register, so the next candidate can be taken
// while the previous verdict waits on m_tready.
`include "assert_macros.svh"

module miller_rabin_prime_test (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [mrpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mrpt_pkg::CFG_W-1:0]       cfg_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mrpt_pkg::NUM_W-1:0]       s_tdata,   // [31:0] candidate
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mrpt_pkg::OUT_W-1:0]       m_tdata    // [0] probably_prime,
                                                        // [32:1] tested_value
);
    import mrpt_pkg::*;

    logic [RND_W-1:0] round_count_reg, round_count_next;
    logic [RND_W-1:0] rounds_eff;
    logic             seed_we;
    logic             lfsr_step;
    logic [NUM_W-1:0] lfsr_state;
    logic             out_free;
    logic             out_valid_reg, out_valid_next;
    logic             out_prime_reg, out_prime_next;
    logic [NUM_W-1:0] out_value_reg, out_value_next;
    mm_req_t          mm_req;
    mm_rsp_t          mm_rsp;
    ctrl_res_t        res;

    // configuration writes
    always_comb
    begin
        round_count_next = round_count_reg;
        if (cfg_we && cfg_index == CFG_ROUND_COUNT)
        begin
            round_count_next = cfg_data[RND_W-1:0];
        end
    end

    assign seed_we = cfg_we && (cfg_index == CFG_RANDOM_SEED);

    // zero rounds means one, more than eight saturate
    assign rounds_eff = (round_count_reg == '0)       ? RND_W'(1)  :
                        (round_count_reg > MAX_ROUNDS) ? MAX_ROUNDS :
                                                         round_count_reg;

    mrpt_lfsr u_lfsr (
        .clk     (clk),
        .rst_n   (rst_n),
        .seed_we (seed_we),
        .seed    (cfg_data[NUM_W-1:0]),
        .step    (lfsr_step),
        .state   (lfsr_state)
    );

    mrpt_mulmod u_mulmod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mm_req),
        .rsp   (mm_rsp)
    );

    mrpt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_data    (s_tdata),
        .in_ready   (s_tready),
        .rounds     (rounds_eff),
        .lfsr_state (lfsr_state),
        .lfsr_step  (lfsr_step),
        .mm_req     (mm_req),
        .mm_rsp     (mm_rsp),
        .out_free   (out_free),
        .res        (res)
    );

    // output register, free when empty or being taken
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_prime_next = out_prime_reg;
        out_value_next = out_value_reg;
        if (res.finish && out_free)
        begin
            out_valid_next = 1'b1;
            out_prime_next = res.prime;
            out_value_next = res.value;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_count_reg <= ROUNDS_RESET;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            round_count_reg <= round_count_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_prime_reg <= out_prime_next;
        out_value_reg <= out_value_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - NUM_W - 1){1'b0}}, out_value_reg, out_prime_reg};

    // checks
    `ASSERT_CLK(busy_after_accept, clk, rst_n, (s_tvalid && s_tready) |=> !s_tready)
    `ASSERT_CLK(verdict_lands, clk, rst_n, (res.finish && out_free) |=> m_tvalid)
    `ASSERT_CLK(valid_from_verdict, clk, rst_n, $rose(m_tvalid) |-> $past(res.finish))
    `ASSERT_NEVER(start_while_idle, clk, rst_n, mm_req.start && s_tready)

endmodule

// ----- tb/sv/primality_verdict_checker.sv -----
// checker that predicts and compares the verdicts of the miller-rabin prime tester
module primality_verdict_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mrpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mrpt_pkg::CFG_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [mrpt_pkg::NUM_W-1:0]      s_tdata,    // [31:0] candidate
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [mrpt_pkg::OUT_W-1:0]      m_tdata,    // [0] probably_prime,
                                                        // [32:1] tested_value
    output int unsigned                     failures,
    output int unsigned                     outstanding
);
    import mrpt_pkg::*;

    localparam int unsigned REPORT_LIMIT = 10;

    typedef struct packed {
        bit             prime;
        bit [NUM_W-1:0] value;
    } verdict_t;

    // verdicts still owed by the block, oldest first
    verdict_t       expected_verdicts[$];
    verdict_t       oldest;
    bit [NUM_W-1:0] witness_lfsr;
    bit [RND_W-1:0] round_setting;
    int unsigned    fail_total;

    // 64-bit product reduced modulo m
    function automatic bit [NUM_W-1:0] mul_mod_n(input bit [NUM_W-1:0] x, y, m);
        bit [2*NUM_W-1:0] product;
        product = {{NUM_W{1'b0}}, x} * {{NUM_W{1'b0}}, y};
        return NUM_W'(product % {{NUM_W{1'b0}}, m});
    endfunction

    // miller-rabin verdict for one candidate, stepping the witness lfsr per round run
    function automatic bit predict_probably_prime(input bit [NUM_W-1:0] n);
        bit [NUM_W-1:0] odd_part;
        bit [NUM_W-1:0] witness;
        bit [NUM_W-1:0] x;
        bit [NUM_W-1:0] base;
        bit [NUM_W-1:0] exponent;
        bit             shifted_out;
        bit             round_ok;
        bit             prime;
        int unsigned    halvings;
        int unsigned    rounds;
        int unsigned    k;
        int unsigned    i;
        // small candidates are settled without touching the lfsr
        if (n <= 1 || n == FOUR)
            return 1'b0;
        if (n <= 3)
            return 1'b1;
        odd_part = n - 1;
        halvings = 0;
        while (!odd_part[0])
        begin
            odd_part = odd_part >> 1;
            halvings++;
        end
        // zero rounds means one, anything above eight saturates
        if (round_setting == 0)
            rounds = 1;
        else if (round_setting > MAX_ROUNDS)
            rounds = 32'(MAX_ROUNDS);
        else
            rounds = 32'(round_setting);
        prime = 1'b1;
        for (k = 0; k < rounds; k++)
        begin
            // galois lfsr step gives the round's random value
            shifted_out = witness_lfsr[0];
            witness_lfsr = witness_lfsr >> 1;
            if (shifted_out)
                witness_lfsr = witness_lfsr ^ LFSR_TAPS;
            witness = TWO + witness_lfsr % (n - FOUR);
            // square-and-multiply for witness^odd_part mod n
            x = 1;
            base = witness % n;
            exponent = odd_part;
            while (exponent != 0)
            begin
                if (exponent[0])
                    x = mul_mod_n(x, base, n);
                exponent = exponent >> 1;
                base = mul_mod_n(base, base, n);
            end
            round_ok = (x == 1 || x == n - 1);
            for (i = 1; i < halvings && !round_ok && x != 1; i++)
            begin
                x = mul_mod_n(x, x, n);
                if (x == n - 1)
                    round_ok = 1'b1;
            end
            // a failed round ends the test, later rounds do not step the lfsr
            if (!round_ok)
            begin
                prime = 1'b0;
                break;
            end
        end
        return prime;
    endfunction

    // track configuration, predict on accepted candidates, compare accepted results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            witness_lfsr = LFSR_RESET;
            round_setting = ROUNDS_RESET;
            expected_verdicts.delete();
            fail_total = 0;
            failures <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROUND_COUNT: round_setting = cfg_data[RND_W-1:0];
                    CFG_RANDOM_SEED: witness_lfsr = (cfg_data != '0) ? cfg_data : LFSR_RESET;
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected result item: probably_prime=%0b tested_value=%0d",
                                 m_tdata[0], m_tdata[NUM_W:1]);
                end
                else
                begin
                    oldest = expected_verdicts.pop_front();
                    if (m_tdata[0] !== oldest.prime || m_tdata[NUM_W:1] !== oldest.value)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                        begin
                            $display("verdict mismatch: expected probably_prime=%0b tested_value=%0d",
                                     oldest.prime, oldest.value);
                            $display("                  got probably_prime=%0b tested_value=%0d",
                                     m_tdata[0], m_tdata[NUM_W:1]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_verdicts.push_back('{prime: predict_probably_prime(s_tdata),
                                              value: s_tdata});
            failures <= fail_total;
            outstanding <= expected_verdicts.size();
        end
    end

endmodule

// ----- tb/sv/miller_rabin_prime_test_tb.sv -----
// testbench top: stimulus, stalls and verdict for the miller-rabin prime tester
module miller_rabin_prime_test_tb;

    import mrpt_pkg::*;

    localparam int unsigned RESET_CYCLES     = 11;
    localparam int unsigned LONG_HOLD_CYCLES = 3000;
    localparam int unsigned RANDOM_PHASES    = 5;
    localparam int unsigned ITEMS_PER_PHASE  = 14;
    localparam int unsigned DRAIN_CYCLES     = 100;
    // about 100 items at eight full-width rounds with stalls, with a fourfold margin
    localparam longint unsigned CYCLE_LIMIT  = 15_000_000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [NUM_W-1:0]     s_tdata;    // [31:0] candidate
    logic                 m_tvalid;
    logic                 m_tready;
    logic [OUT_W-1:0]     m_tdata;    // [0] probably_prime, [32:1] tested_value

    int unsigned     failures;
    int unsigned     outstanding;
    logic            stall_window;
    logic            hold_active;
    bit              hold_done;
    longint unsigned cycle_count = 0;

    miller_rabin_prime_test DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    primality_verdict_checker verdict_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .failures    (failures),
        .outstanding (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // offer one candidate after a random gap and wait until it is taken
    task automatic send_candidate(input bit [NUM_W-1:0] n);
        int unsigned roll;
        int unsigned gap;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            gap = 0;
        else if (roll < 90)
            gap = $urandom_range(1, 3);
        else if (roll < 98)
            gap = $urandom_range(4, 20);
        else
            gap = $urandom_range(50, 200);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= n;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // stop offering and wait for every owed verdict
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // single-cycle register write
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // result side: random ready pattern plus one long hold-off on request
    initial
    begin : result_sink
        int unsigned pick;
        int unsigned span;
        m_tready = 1'b0;
        hold_active = 1'b0;
        hold_done = 1'b0;
        repeat (RESET_CYCLES + 1) @(posedge clk);
        forever
        begin
            if (stall_window && !hold_done)
            begin
                m_tready <= 1'b0;
                hold_active <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                hold_active <= 1'b0;
                hold_done = 1'b1;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    m_tready <= 1'b1;
                    span = $urandom_range(1, 24);
                end
                else if (pick < 60)
                begin
                    m_tready <= 1'b1;
                    span = $urandom_range(100, 600);
                end
                else if (pick < 90)
                begin
                    m_tready <= 1'b0;
                    span = $urandom_range(1, 4);
                end
                else if (pick < 98)
                begin
                    m_tready <= 1'b0;
                    span = $urandom_range(5, 40);
                end
                else
                begin
                    m_tready <= 1'b0;
                    span = $urandom_range(100, 400);
                end
                repeat (span) @(posedge clk);
            end
        end
    end

    // stimulus
    initial
    begin : stimulus
        bit [NUM_W-1:0] work_list[$];
        bit [NUM_W-1:0] n;
        bit [CFG_W-1:0] word;
        bit [RND_W-1:0] rounds_pick;
        int unsigned    phase;
        int unsigned    item;
        int unsigned    roll;
        int unsigned    bits;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROUND_COUNT;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        stall_window = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: small decided values, carmichael and pseudoprimes, field extremes
        work_list = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd7, 32'd9,
                      32'd561, 32'd2047, 32'd65537, 32'hFFFF_FFFF, 32'hFFFF_FFFB,
                      32'h8000_0000, 32'hAAAA_AAAB, 32'h5555_5555};
        foreach (work_list[i])
            send_candidate(work_list[i]);
        drain_results();

        // most rounds, all-ones seed, large primes and long halving chains
        write_register(CFG_ROUND_COUNT, CFG_W'(MAX_ROUNDS));
        write_register(CFG_RANDOM_SEED, '1);
        work_list = '{32'd2147483647, 32'd3215031751, 32'd3221225473};
        foreach (work_list[i])
            send_candidate(work_list[i]);
        drain_results();

        // zero round count acts as one round, zero seed loads one
        write_register(CFG_ROUND_COUNT, '0);
        write_register(CFG_RANDOM_SEED, '0);
        work_list = '{32'd561, 32'd2047, 32'd1373653};
        foreach (work_list[i])
            send_candidate(work_list[i]);
        drain_results();

        // round count above eight saturates
        write_register(CFG_ROUND_COUNT, 32'd15);
        write_register(CFG_RANDOM_SEED, $urandom);
        work_list = '{32'd4294967291, 32'd25326001};
        foreach (work_list[i])
            send_candidate(work_list[i]);
        drain_results();

        // single round; hold the result side off so the block backs up into its input
        write_register(CFG_ROUND_COUNT, 32'd1);
        write_register(CFG_RANDOM_SEED, 32'd1);
        stall_window <= 1'b1;
        @(posedge clk);
        while (!hold_active)
            @(posedge clk);
        work_list = '{32'd0, 32'd2, 32'd4, 32'd1, 32'd3, 32'd9, 32'd15, 32'd2};
        foreach (work_list[i])
            send_candidate(work_list[i]);
        drain_results();
        stall_window <= 1'b0;

        // random settings and candidates, mostly narrow and odd so primes show up often
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            rounds_pick = RND_W'($urandom_range(0, 15));
            word = $urandom;
            word[RND_W-1:0] = rounds_pick;
            write_register(CFG_ROUND_COUNT, word);
            if ($urandom_range(0, 99) < 15)
                write_register(CFG_RANDOM_SEED, '0);
            else
                write_register(CFG_RANDOM_SEED, $urandom);
            for (item = 0; item < ITEMS_PER_PHASE; item++)
            begin
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    n = $urandom_range(0, 4);
                else
                begin
                    if (roll < 65)
                        bits = $urandom_range(3, 16);
                    else if (roll < 90)
                        bits = $urandom_range(17, 24);
                    else
                        bits = $urandom_range(25, 32);
                    n = $urandom;
                    if (bits < NUM_W)
                        n = n & ((32'd1 << bits) - 1);
                    n[bits-1] = 1'b1;
                    if ($urandom_range(0, 3) != 0)
                        n[0] = 1'b1;
                end
                send_candidate(n);
            end
            drain_results();
        end

        // let any late item show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (failures == 0 && outstanding == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
